### rtl/serial_frame_parser_dual_checksum_macros.svh
// Assertion macros for the serial frame parser.
// Used by serial_frame_parser_dual_checksum.sv; no other dependencies.
`ifndef SERIAL_FRAME_PARSER_DUAL_CHECKSUM_MACROS_SVH
`define SERIAL_FRAME_PARSER_DUAL_CHECKSUM_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SFPDC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SFPDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfpdc_pkg.sv
// Shared types and constants for the serial frame parser.
// No dependencies.
`timescale 1ns / 1ps

package sfpdc_pkg;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_CODE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_XOR   = 3'd5,
    PH_SUM   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_POINT      = 2'd0,
    KIND_DRAW_READY = 2'd1,
    KIND_DRAW_POINT = 2'd2
  } kind_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_POINT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_DRAW_READY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_DRAW_POINT = 3'd4;

  localparam logic [7:0] RST_HEADER_FIRST    = 8'hAA;
  localparam logic [7:0] RST_HEADER_SECOND   = 8'hFF;
  localparam logic [7:0] RST_CODE_POINT      = 8'hF2;
  localparam logic [7:0] RST_CODE_DRAW_READY = 8'hE1;
  localparam logic [7:0] RST_CODE_DRAW_POINT = 8'hE2;

  // Only payload bytes 0..3 ever reach the outputs.
  localparam int STORE_BYTES = 4;

endpackage

### rtl/serial_frame_parser_dual_checksum.sv
// Serial frame parser with XOR and additive check bytes.
// Depends on sfpdc_pkg and serial_frame_parser_dual_checksum_macros.svh.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid / in_ready | rx_byte, line_abort
//   result   | out_valid/out_ready | frame_kind, check_ok, x_coord, y_coord,
//            |                     | good_point_total, check_fail_total
//   config   | cfg_write           | cfg_index, cfg_data
//
// One item per cycle; a result shows in the output register in the cycle
// after the check-sum byte is accepted. in_ready drops only while a result
// sits unread and out_ready is low. Synchronous reset clears the parser, the
// payload bytes, both counts and the registers to their defaults.
`timescale 1ns / 1ps
`include "serial_frame_parser_dual_checksum_macros.svh"

module serial_frame_parser_dual_checksum #(
  parameter int PAYLOAD_MAX = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            line_abort,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      frame_kind,
  output logic                            check_ok,
  output logic [15:0]                     x_coord,
  output logic [15:0]                     y_coord,
  output logic [31:0]                     good_point_total,
  output logic [31:0]                     check_fail_total,
  input  logic                            cfg_write,
  input  logic [sfpdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam int LW = $clog2(PAYLOAD_MAX + 1);
  localparam logic [7:0]    LEN_LIMIT = 8'(PAYLOAD_MAX);
  localparam logic [LW-1:0] STORE_LIM = LW'(sfpdc_pkg::STORE_BYTES);

  logic [7:0] header_first, header_second;
  logic [7:0] code_point, code_draw_ready, code_draw_point;

  sfpdc_pkg::phase_t phase, phase_next;
  logic [7:0]    frame_code, frame_code_next;
  logic [LW-1:0] frame_length, frame_length_next;
  logic [LW-1:0] payload_position, payload_position_next;
  logic [7:0]    payload_store [sfpdc_pkg::STORE_BYTES];
  logic [7:0]    running_xor, running_xor_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    received_xor, received_xor_next;
  logic [31:0]   good_point_count, good_point_count_next;
  logic [31:0]   fail_count, fail_count_next;

  logic          in_fire;
  logic          step;
  logic          code_known;
  logic          len_ok;
  logic [LW-1:0] pos_inc;
  logic          store_we;
  logic          result_we;
  logic          ok;
  sfpdc_pkg::kind_t kind;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign step     = in_fire && !line_abort;

  assign code_known = (frame_code == code_point) || (frame_code == code_draw_point) ||
                      (frame_code == code_draw_ready);
  assign len_ok  = (rx_byte <= LEN_LIMIT) && code_known;
  assign pos_inc = payload_position + LW'(1);
  assign ok      = (received_xor == running_xor) && (rx_byte == running_sum);

  always_comb begin
    if (frame_code == code_point) begin
      kind = sfpdc_pkg::KIND_POINT;
    end else if (frame_code == code_draw_ready) begin
      kind = sfpdc_pkg::KIND_DRAW_READY;
    end else begin
      kind = sfpdc_pkg::KIND_DRAW_POINT;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (in_fire && line_abort) begin
      phase_next = sfpdc_pkg::PH_HEAD1;
    end else if (step) begin
      case (phase)
        sfpdc_pkg::PH_HEAD1: begin
          if (rx_byte == header_first) phase_next = sfpdc_pkg::PH_HEAD2;
        end
        sfpdc_pkg::PH_HEAD2: begin
          if (rx_byte == header_second) begin
            phase_next = sfpdc_pkg::PH_CODE;
          end else if (rx_byte != header_first) begin
            phase_next = sfpdc_pkg::PH_HEAD1;
          end
        end
        sfpdc_pkg::PH_CODE: phase_next = sfpdc_pkg::PH_LEN;
        sfpdc_pkg::PH_LEN: begin
          if (!len_ok) begin
            phase_next = sfpdc_pkg::PH_HEAD1;
          end else if (rx_byte == 8'd0) begin
            phase_next = sfpdc_pkg::PH_XOR;
          end else begin
            phase_next = sfpdc_pkg::PH_DATA;
          end
        end
        sfpdc_pkg::PH_DATA: begin
          if (pos_inc >= frame_length) phase_next = sfpdc_pkg::PH_XOR;
        end
        sfpdc_pkg::PH_XOR: phase_next = sfpdc_pkg::PH_SUM;
        sfpdc_pkg::PH_SUM: phase_next = sfpdc_pkg::PH_HEAD1;
        default:           phase_next = sfpdc_pkg::PH_HEAD1;
      endcase
    end
  end

  // parser fields, counts and result strobe
  always_comb begin
    frame_code_next       = frame_code;
    frame_length_next     = frame_length;
    payload_position_next = payload_position;
    running_xor_next      = running_xor;
    running_sum_next      = running_sum;
    received_xor_next     = received_xor;
    good_point_count_next = good_point_count;
    fail_count_next       = fail_count;
    store_we              = 1'b0;
    result_we             = 1'b0;
    if (in_fire && line_abort) begin
      frame_code_next       = '0;
      frame_length_next     = '0;
      payload_position_next = '0;
      running_xor_next      = '0;
      running_sum_next      = '0;
      received_xor_next     = '0;
    end else if (step) begin
      case (phase)
        sfpdc_pkg::PH_HEAD1: ;
        sfpdc_pkg::PH_HEAD2: begin
          if (rx_byte == header_second) begin
            running_xor_next = header_first ^ header_second;
            running_sum_next = header_first + header_second;
          end
        end
        sfpdc_pkg::PH_CODE: begin
          frame_code_next  = rx_byte;
          running_xor_next = running_xor ^ rx_byte;
          running_sum_next = running_sum + rx_byte;
        end
        sfpdc_pkg::PH_LEN: begin
          if (len_ok) begin
            frame_length_next     = rx_byte[LW-1:0];
            payload_position_next = '0;
            running_xor_next      = running_xor ^ rx_byte;
            running_sum_next      = running_sum + rx_byte;
          end else begin
            frame_code_next       = '0;
            frame_length_next     = '0;
            payload_position_next = '0;
            running_xor_next      = '0;
            running_sum_next      = '0;
            received_xor_next     = '0;
          end
        end
        sfpdc_pkg::PH_DATA: begin
          store_we              = payload_position < STORE_LIM;
          running_xor_next      = running_xor ^ rx_byte;
          running_sum_next      = running_sum + rx_byte;
          payload_position_next = pos_inc;
        end
        sfpdc_pkg::PH_XOR: received_xor_next = rx_byte;
        sfpdc_pkg::PH_SUM: begin
          result_we = 1'b1;
          if (ok) begin
            if (kind == sfpdc_pkg::KIND_POINT) begin
              good_point_count_next = good_point_count + 32'd1;
            end
          end else begin
            fail_count_next = fail_count + 32'd1;
          end
          frame_code_next       = '0;
          frame_length_next     = '0;
          payload_position_next = '0;
          running_xor_next      = '0;
          running_sum_next      = '0;
          received_xor_next     = '0;
        end
        default: begin
          frame_code_next       = '0;
          frame_length_next     = '0;
          payload_position_next = '0;
          running_xor_next      = '0;
          running_sum_next      = '0;
          received_xor_next     = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= sfpdc_pkg::RST_HEADER_FIRST;
      header_second   <= sfpdc_pkg::RST_HEADER_SECOND;
      code_point      <= sfpdc_pkg::RST_CODE_POINT;
      code_draw_ready <= sfpdc_pkg::RST_CODE_DRAW_READY;
      code_draw_point <= sfpdc_pkg::RST_CODE_DRAW_POINT;
    end else if (cfg_write) begin
      case (cfg_index)
        sfpdc_pkg::REG_HEADER_FIRST:    header_first    <= cfg_data;
        sfpdc_pkg::REG_HEADER_SECOND:   header_second   <= cfg_data;
        sfpdc_pkg::REG_CODE_POINT:      code_point      <= cfg_data;
        sfpdc_pkg::REG_CODE_DRAW_READY: code_draw_ready <= cfg_data;
        sfpdc_pkg::REG_CODE_DRAW_POINT: code_draw_point <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sfpdc_pkg::PH_HEAD1;
      frame_code       <= '0;
      frame_length     <= '0;
      payload_position <= '0;
      running_xor      <= '0;
      running_sum      <= '0;
      received_xor     <= '0;
      good_point_count <= '0;
      fail_count       <= '0;
    end else begin
      phase            <= phase_next;
      frame_code       <= frame_code_next;
      frame_length     <= frame_length_next;
      payload_position <= payload_position_next;
      running_xor      <= running_xor_next;
      running_sum      <= running_sum_next;
      received_xor     <= received_xor_next;
      good_point_count <= good_point_count_next;
      fail_count       <= fail_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sfpdc_pkg::STORE_BYTES; i++) payload_store[i] <= '0;
    end else if (store_we) begin
      payload_store[payload_position[1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_we) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload; the store is read after this frame's last data byte
  always_ff @(posedge clk) begin
    if (result_we) begin
      frame_kind       <= kind;
      check_ok         <= ok;
      x_coord          <= {payload_store[1], payload_store[0]};
      y_coord          <= {payload_store[3], payload_store[2]};
      good_point_total <= good_point_count_next;
      check_fail_total <= fail_count_next;
    end
  end

  `SFPDC_ASSERT_IMPL(a_data_len, clk, rst, phase == sfpdc_pkg::PH_DATA, frame_length != '0, "data phase with zero length")
  `SFPDC_ASSERT_NEXT(a_sum_result, clk, rst, step && phase == sfpdc_pkg::PH_SUM, out_valid && phase == sfpdc_pkg::PH_HEAD1, "check-sum byte gave no result")
  `SFPDC_ASSERT_NEXT(a_abort_clear, clk, rst, in_fire && line_abort, phase == sfpdc_pkg::PH_HEAD1 && running_xor == '0 && running_sum == '0, "abort left parser armed")
  `SFPDC_ASSERT_NEXT(a_fail_count, clk, rst, step && phase == sfpdc_pkg::PH_SUM, check_fail_total == $past(fail_count) + 32'(!check_ok), "fail count out of step")

endmodule

### dv/tb_serial_frame_parser_dual_checksum.sv
// Self-checking testbench for serial_frame_parser_dual_checksum.
// Runs directed and random byte streams through the parser and checks each result item.
// Depends on sfpdc_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_serial_frame_parser_dual_checksum;

  localparam int PAYLOAD_MAX = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDX_W = sfpdc_pkg::CFG_IDX_W;

  typedef enum int {CHK_GOOD, CHK_BAD_XOR, CHK_BAD_SUM, CHK_BAD_BOTH} check_fault_t;

  typedef struct {
    sfpdc_pkg::kind_t kind;
    logic        ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] good;
    logic [31:0] fail;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic line_abort = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] frame_kind;
  logic check_ok;
  logic [15:0] x_coord;
  logic [15:0] y_coord;
  logic [31:0] good_point_total;
  logic [31:0] check_fail_total;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = sfpdc_pkg::REG_HEADER_FIRST;
  logic [7:0] cfg_data = 8'h00;

  // register copies
  logic [7:0] reg_hdr_first = sfpdc_pkg::RST_HEADER_FIRST;
  logic [7:0] reg_hdr_second = sfpdc_pkg::RST_HEADER_SECOND;
  logic [7:0] reg_code_point = sfpdc_pkg::RST_CODE_POINT;
  logic [7:0] reg_code_ready = sfpdc_pkg::RST_CODE_DRAW_READY;
  logic [7:0] reg_code_draw = sfpdc_pkg::RST_CODE_DRAW_POINT;

  // parser state copy
  sfpdc_pkg::phase_t ps_phase = sfpdc_pkg::PH_HEAD1;
  logic [7:0]  ps_code = 8'h00;
  logic [3:0]  ps_len = 4'd0;
  logic [3:0]  ps_pos = 4'd0;
  logic [7:0]  ps_store [PAYLOAD_MAX];
  logic [7:0]  ps_xor = 8'h00;
  logic [7:0]  ps_sum = 8'h00;
  logic [7:0]  ps_rx_xor = 8'h00;
  logic [31:0] ps_good = 32'd0;
  logic [31:0] ps_fail = 32'd0;

  frame_result_t expected_frames[$];
  logic [7:0] frame_bytes[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int frame_items = 0;
  int send_gap_pct = 20;
  int stall_pct = 20;
  int stall_left = 0;
  int idle_cycles = 0;

  serial_frame_parser_dual_checksum #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .line_abort(line_abort),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_kind(frame_kind),
    .check_ok(check_ok),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .good_point_total(good_point_total),
    .check_fail_total(check_fail_total),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int idle_length(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", results_seen, field, got, want);
    mismatch_count++;
  endtask

  task restart_hunt();
    ps_phase = sfpdc_pkg::PH_HEAD1;
    ps_code = 8'h00;
    ps_len = 4'd0;
    ps_pos = 4'd0;
    ps_xor = 8'h00;
    ps_sum = 8'h00;
    ps_rx_xor = 8'h00;
  endtask

  task advance_parser(input logic [7:0] b, input logic abort);
    frame_result_t r;
    if (abort) begin
      restart_hunt();
      return;
    end
    case (ps_phase)
      sfpdc_pkg::PH_HEAD1: begin
        if (b == reg_hdr_first) ps_phase = sfpdc_pkg::PH_HEAD2;
      end
      sfpdc_pkg::PH_HEAD2: begin
        if (b == reg_hdr_second) begin
          ps_xor = reg_hdr_first ^ reg_hdr_second;
          ps_sum = reg_hdr_first + reg_hdr_second;
          ps_phase = sfpdc_pkg::PH_CODE;
        end else if (b != reg_hdr_first) begin
          ps_phase = sfpdc_pkg::PH_HEAD1;
        end
      end
      sfpdc_pkg::PH_CODE: begin
        ps_code = b;
        ps_xor ^= b;
        ps_sum += b;
        ps_phase = sfpdc_pkg::PH_LEN;
      end
      sfpdc_pkg::PH_LEN: begin
        if (b <= 8'(PAYLOAD_MAX) && (ps_code == reg_code_point || ps_code == reg_code_draw ||
                                     ps_code == reg_code_ready)) begin
          ps_len = b[3:0];
          ps_pos = 4'd0;
          ps_xor ^= b;
          ps_sum += b;
          ps_phase = (b == 8'd0) ? sfpdc_pkg::PH_XOR : sfpdc_pkg::PH_DATA;
        end else begin
          restart_hunt();
        end
      end
      sfpdc_pkg::PH_DATA: begin
        ps_store[ps_pos[2:0]] = b;
        ps_xor ^= b;
        ps_sum += b;
        ps_pos = ps_pos + 4'd1;
        if (ps_pos >= ps_len) ps_phase = sfpdc_pkg::PH_XOR;
      end
      sfpdc_pkg::PH_XOR: begin
        ps_rx_xor = b;
        ps_phase = sfpdc_pkg::PH_SUM;
      end
      sfpdc_pkg::PH_SUM: begin
        r.ok = (ps_rx_xor == ps_xor) && (b == ps_sum);
        if (ps_code == reg_code_point) r.kind = sfpdc_pkg::KIND_POINT;
        else if (ps_code == reg_code_ready) r.kind = sfpdc_pkg::KIND_DRAW_READY;
        else r.kind = sfpdc_pkg::KIND_DRAW_POINT;
        if (!r.ok) ps_fail++;
        else if (r.kind == sfpdc_pkg::KIND_POINT) ps_good++;
        r.x = {ps_store[1], ps_store[0]};
        r.y = {ps_store[3], ps_store[2]};
        r.good = ps_good;
        r.fail = ps_fail;
        expected_frames.push_back(r);
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endtask

  task send_item(input logic [7:0] b, input logic abort);
    int gap;
    in_valid <= 1'b1;
    rx_byte <= b;
    line_abort <= abort;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_parser(b, abort);
    gap = idle_length(send_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_range(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      send_item(frame_bytes[i], 1'b0);
      frame_items++;
    end
  endtask

  // header, header, code, length, payload, xor check, sum check
  task build_frame(input logic [7:0] code, input int len, input check_fault_t fault);
    logic [7:0] x;
    logic [7:0] s;
    frame_bytes = {};
    frame_bytes.push_back(reg_hdr_first);
    frame_bytes.push_back(reg_hdr_second);
    frame_bytes.push_back(code);
    frame_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    x = 8'h00;
    s = 8'h00;
    foreach (frame_bytes[i]) begin
      x ^= frame_bytes[i];
      s += frame_bytes[i];
    end
    if (fault == CHK_BAD_XOR || fault == CHK_BAD_BOTH) x ^= 8'($urandom_range(1, 255));
    if (fault == CHK_BAD_SUM || fault == CHK_BAD_BOTH) s ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(x);
    frame_bytes.push_back(s);
  endtask

  task send_frame(input logic [7:0] code, input int len, input check_fault_t fault);
    build_frame(code, len, fault);
    send_range(0, frame_bytes.size());
  endtask

  task drain();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task write_register(input logic [IDX_W-1:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      sfpdc_pkg::REG_HEADER_FIRST:    reg_hdr_first = value;
      sfpdc_pkg::REG_HEADER_SECOND:   reg_hdr_second = value;
      sfpdc_pkg::REG_CODE_POINT:      reg_code_point = value;
      sfpdc_pkg::REG_CODE_DRAW_READY: reg_code_ready = value;
      sfpdc_pkg::REG_CODE_DRAW_POINT: reg_code_draw = value;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task set_registers(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] cp,
                     input logic [7:0] cr, input logic [7:0] cd);
    drain();
    write_register(sfpdc_pkg::REG_HEADER_FIRST, hf);
    write_register(sfpdc_pkg::REG_HEADER_SECOND, hs);
    write_register(sfpdc_pkg::REG_CODE_POINT, cp);
    write_register(sfpdc_pkg::REG_CODE_DRAW_READY, cr);
    write_register(sfpdc_pkg::REG_CODE_DRAW_POINT, cd);
  endtask

  function logic [7:0] pick_code();
    case (sfpdc_pkg::kind_t'($urandom_range(sfpdc_pkg::KIND_POINT,
                                            sfpdc_pkg::KIND_DRAW_POINT)))
      sfpdc_pkg::KIND_POINT:      return reg_code_point;
      sfpdc_pkg::KIND_DRAW_READY: return reg_code_ready;
      default:                    return reg_code_draw;
    endcase
  endfunction

  function logic [7:0] unknown_code();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == reg_code_point || c == reg_code_ready || c == reg_code_draw)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function check_fault_t pick_fault();
    if ($urandom_range(0, 99) < 80) return CHK_GOOD;
    return check_fault_t'($urandom_range(CHK_BAD_XOR, CHK_BAD_BOTH));
  endfunction

  task test_frame_kinds();
    send_frame(reg_code_point, 4, CHK_GOOD);
    send_frame(reg_code_ready, 0, CHK_GOOD);
    send_frame(reg_code_draw, PAYLOAD_MAX, CHK_GOOD);
    send_frame(reg_code_point, 1, CHK_BAD_XOR);
    send_frame(reg_code_point, 2, CHK_BAD_SUM);
  endtask

  task test_header_hunt();
    send_item(8'h00, 1'b0);
    send_item(reg_hdr_first, 1'b0);
    send_item(reg_hdr_first, 1'b0);
    send_frame(reg_code_point, 4, CHK_GOOD);
    send_item(reg_hdr_first, 1'b0);
    send_item(reg_hdr_first ^ 8'h5A, 1'b0);
    send_frame(reg_code_draw, 0, CHK_GOOD);
    send_item(reg_hdr_first, 1'b0);
    send_item(reg_hdr_second, 1'b1);
    send_item(reg_hdr_second, 1'b0);
    send_frame(reg_code_ready, 1, CHK_GOOD);
  endtask

  task test_rejects_and_aborts();
    build_frame(reg_code_point, 2, CHK_GOOD);
    frame_bytes[2] = unknown_code();
    send_range(0, frame_bytes.size());
    build_frame(reg_code_point, 0, CHK_GOOD);
    frame_bytes[3] = 8'(PAYLOAD_MAX + 1);
    send_range(0, 4);
    frame_bytes[3] = 8'hFF;
    send_range(0, 4);
    build_frame(reg_code_draw, 6, CHK_GOOD);
    send_range(0, 6);
    send_item(reg_hdr_first, 1'b1);
    send_frame(reg_code_point, 0, CHK_GOOD);
  endtask

  // registers rewritten between the length byte and the payload
  task test_mid_frame_config();
    logic [7:0] old_point;
    old_point = reg_code_point;
    build_frame(reg_code_point, 4, CHK_GOOD);
    send_range(0, 4);
    drain();
    write_register(sfpdc_pkg::REG_HEADER_FIRST, 8'h5A);
    write_register(sfpdc_pkg::REG_HEADER_SECOND, 8'hA5);
    write_register(sfpdc_pkg::REG_CODE_POINT, ~old_point);
    write_register(sfpdc_pkg::REG_CODE_DRAW_READY, old_point);
    send_range(4, frame_bytes.size());
    send_frame(old_point, 3, CHK_GOOD);
    set_registers(sfpdc_pkg::RST_HEADER_FIRST, sfpdc_pkg::RST_HEADER_SECOND,
                  sfpdc_pkg::RST_CODE_POINT, sfpdc_pkg::RST_CODE_DRAW_READY,
                  sfpdc_pkg::RST_CODE_DRAW_POINT);
  endtask

  task test_random_traffic(input int budget, input int in_gap, input int out_stall);
    int stop_at;
    int sel;
    int cut;
    send_gap_pct = in_gap;
    stall_pct = out_stall;
    stop_at = frame_items + budget;
    while (frame_items < stop_at) begin
      sel = $urandom_range(0, 99);
      build_frame(pick_code(), $urandom_range(0, PAYLOAD_MAX), pick_fault());
      if (sel < 66) begin
        send_range(0, frame_bytes.size());
      end else if (sel < 72) begin
        repeat ($urandom_range(1, 3)) send_item(reg_hdr_first, 1'b0);
        send_range(0, frame_bytes.size());
      end else if (sel < 78) begin
        cut = $urandom_range(3, frame_bytes.size() - 1);
        send_range(0, cut);
        drain();
        write_register(IDX_W'($urandom_range(sfpdc_pkg::REG_HEADER_FIRST,
                                             sfpdc_pkg::REG_CODE_DRAW_POINT)),
                       8'($urandom_range(0, 255)));
        send_range(cut, frame_bytes.size());
      end else if (sel < 85) begin
        cut = $urandom_range(0, frame_bytes.size() - 1);
        send_range(0, cut);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (sel < 89) begin
        frame_bytes[2] = unknown_code();
        send_range(0, frame_bytes.size());
      end else if (sel < 93) begin
        frame_bytes[3] = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
        send_range(0, 4);
      end else if (sel < 98) begin
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        drain();
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result, frame_kind", 32'(frame_kind), 32'd0);
      end else begin
        want = expected_frames.pop_front();
        if (frame_kind !== want.kind)
          report_mismatch("frame_kind", 32'(frame_kind), 32'(want.kind));
        if (check_ok !== want.ok) report_mismatch("check_ok", 32'(check_ok), 32'(want.ok));
        if (x_coord !== want.x) report_mismatch("x_coord", 32'(x_coord), 32'(want.x));
        if (y_coord !== want.y) report_mismatch("y_coord", 32'(y_coord), 32'(want.y));
        if (good_point_total !== want.good)
          report_mismatch("good_point_total", good_point_total, want.good);
        if (check_fail_total !== want.fail)
          report_mismatch("check_fail_total", check_fail_total, want.fail);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = idle_length(stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] hdr;
    foreach (ps_store[i]) ps_store[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_frame_kinds();
    test_header_hunt();
    test_rejects_and_aborts();
    test_mid_frame_config();
    test_random_traffic(400, 30, 30);
    set_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    test_random_traffic(250, 0, 0);
    set_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    test_random_traffic(250, 15, 60);
    hdr = 8'($urandom_range(0, 255));
    set_registers(hdr, hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    test_random_traffic(250, 40, 10);
    set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    test_random_traffic(250, 25, 25);
    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### serial_frame_parser_dual_checksum.f
+incdir+rtl
rtl/sfpdc_pkg.sv
rtl/serial_frame_parser_dual_checksum.sv
dv/tb_serial_frame_parser_dual_checksum.sv
